// ===== design/sea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sea_pkg
// widths, constants, sideband types and helper functions shared by the
// satellite elevation angle pipeline
// ----------------------------------------------------------------------------
package sea_pkg;

  localparam int IN_W     = 34;   // position field width
  localparam int D_W      = 35;   // line-of-sight component
  localparam int MR_W     = 34;   // magnitude of a receiver component
  localparam int MD_W     = 35;   // magnitude of a line-of-sight component
  localparam int SQ_W     = 70;   // squared norms and dot magnitude
  localparam int DOT_W    = 71;   // signed dot product
  localparam int LEN_W    = 7;    // bit length of a SQ_W word
  localparam int NRM_W    = 126;  // normalized word
  localparam int ROOT_W   = 63;   // root of a normalized word
  localparam int SPLIT_W  = 32;   // partial product split of the roots
  localparam int SH_W     = 8;    // shift counts
  localparam int FRAC_Q   = 30;   // ratio fraction bits
  localparam int Q_W      = 31;   // quotient bits
  localparam int C_W      = 31;   // ratio magnitude, q30
  localparam int CC_W     = 62;   // 1 - c^2, q60
  localparam int COS_W    = 31;   // cosine term, q30
  localparam int CORDIC_N = 30;   // rotation steps
  localparam int CX_W     = 34;   // cordic x and y
  localparam int CZ_W     = 33;   // cordic angle accumulator
  localparam int EL_W     = 22;   // elevation, q20
  localparam int SMALL_W  = 27;   // operand width of the degenerate check
  localparam int RND_SH   = 10;   // q30 to q20

  localparam logic [2*SMALL_W-1:0] DEGEN_LIM = (2*SMALL_W)'(100000000);
  localparam logic [C_W-1:0]       Q30_ONE   = C_W'(1) << FRAC_Q;
  localparam logic [CC_W-1:0]      Q60_ONE   = CC_W'(1) << (2 * FRAC_Q);
  localparam logic [CZ_W-1:0]      HALF_PI_Q30 = CZ_W'(1686629713);
  localparam logic [CZ_W-1:0]      RND_HALF  = CZ_W'(1) << (RND_SH - 1);
  localparam logic [EL_W-1:0]      HALF_PI_Q20 = EL_W'(1647099);

  // sideband that rides with the norm roots
  typedef struct packed {
    logic            neg;
    logic            zero;
    logic            degen;
    logic [SQ_W-1:0] m;
    logic [SH_W-1:0] sha;
    logic [SH_W-1:0] shb;
  } norm_sb_t;

  // flags that ride to the end of the pipe
  typedef struct packed {
    logic neg;
    logic zero;
    logic degen;
  } tail_sb_t;

  // sideband of the cosine root
  typedef struct packed {
    tail_sb_t       t;
    logic [C_W-1:0] c;
  } cos_sb_t;

  function automatic logic [LEN_W-1:0] bitlen(input logic [SQ_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < SQ_W; i++) begin
      if (v[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  // arctangent of 2^-i in q30, rounded to nearest
  function automatic logic [CZ_W-1:0] atan_q30(input int i);
    case (i)
      0: return CZ_W'(843314857);
      1: return CZ_W'(497837829);
      2: return CZ_W'(263043837);
      3: return CZ_W'(133525159);
      4: return CZ_W'(67021687);
      5: return CZ_W'(33543516);
      6: return CZ_W'(16775851);
      7: return CZ_W'(8388437);
      8: return CZ_W'(4194283);
      9: return CZ_W'(2097149);
      default: return CZ_W'(64'd1 << (FRAC_Q - i));
    endcase
  endfunction

  // arithmetic shift right that truncates toward zero
  function automatic logic [CX_W-1:0] shr_tz(input logic [CX_W-1:0] v, input int s);
    logic [CX_W-1:0] a;
    a = v[CX_W-1] ? (~v + 1'b1) : v;
    a = a >> s;
    return v[CX_W-1] ? (~a + 1'b1) : a;
  endfunction

endpackage
`default_nettype wire

// ===== design/sea_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sea_prep
// front end: line of sight, squared norms, dot product, normalization shifts
// and the degenerate check, five register stages
// ----------------------------------------------------------------------------
module sea_prep import sea_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_v,
  input  logic [2:0][IN_W-1:0]      sat,
  input  logic [2:0][IN_W-1:0]      rcv,
  output logic                      out_v,
  output logic [1:0][NRM_W-1:0]     out_x,
  output norm_sb_t                  out_sb
);

  // stage 1: line of sight
  logic                  v1_r;
  logic [2:0][IN_W-1:0]  r1_r;
  logic [2:0][D_W-1:0]   d1_r, d1_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d1_nxt[a] = D_W'($signed(sat[a])) - D_W'($signed(rcv[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_v;
  end

  always_ff @(posedge clk) begin
    r1_r <= rcv;
    d1_r <= d1_nxt;
  end

  // stage 2: products
  logic                       v2_r;
  logic [2:0][MR_W-1:0]       mr;
  logic [2:0][MD_W-1:0]       md;
  logic [2:0][2*MR_W-1:0]     rsq2_r, rsq2_nxt;
  logic [2:0][2*MD_W-1:0]     dsq2_r, dsq2_nxt;
  logic [2:0][IN_W+D_W-1:0]   dot2_r, dot2_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mr[a]       = r1_r[a][IN_W-1] ? (~r1_r[a] + 1'b1) : r1_r[a];
      md[a]       = d1_r[a][D_W-1] ? (~d1_r[a] + 1'b1) : d1_r[a];
      rsq2_nxt[a] = mr[a] * mr[a];
      dsq2_nxt[a] = md[a] * md[a];
      dot2_nxt[a] = $signed(r1_r[a]) * $signed(d1_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    rsq2_r <= rsq2_nxt;
    dsq2_r <= dsq2_nxt;
    dot2_r <= dot2_nxt;
  end

  // stage 3: sums
  logic             v3_r;
  logic [SQ_W-1:0]  r3_r, r3_nxt, s3_r, s3_nxt;
  logic [DOT_W-1:0] dot3_r, dot3_nxt;

  always_comb begin
    r3_nxt   = SQ_W'(rsq2_r[0]) + SQ_W'(rsq2_r[1]) + SQ_W'(rsq2_r[2]);
    s3_nxt   = SQ_W'(dsq2_r[0]) + SQ_W'(dsq2_r[1]) + SQ_W'(dsq2_r[2]);
    dot3_nxt = DOT_W'($signed(dot2_r[0])) + DOT_W'($signed(dot2_r[1]))
             + DOT_W'($signed(dot2_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    r3_r   <= r3_nxt;
    s3_r   <= s3_nxt;
    dot3_r <= dot3_nxt;
  end

  // stage 4: bit lengths and flags
  logic             v4_r;
  logic [SQ_W-1:0]  r4_r, s4_r, m4_r, m4_nxt;
  logic [LEN_W-1:0] lr4_r, ls4_r, lm4_r;
  logic             neg4_r, zr4_r, zs4_r, zm4_r, sr4_r, ss4_r;

  always_comb begin
    m4_nxt = dot3_r[DOT_W-1] ? SQ_W'(~dot3_r + 1'b1) : SQ_W'(dot3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    r4_r   <= r3_r;
    s4_r   <= s3_r;
    m4_r   <= m4_nxt;
    lr4_r  <= bitlen(r3_r);
    ls4_r  <= bitlen(s3_r);
    lm4_r  <= bitlen(m4_nxt);
    neg4_r <= dot3_r[DOT_W-1];
    zr4_r  <= (r3_r == '0);
    zs4_r  <= (s3_r == '0);
    zm4_r  <= (m4_nxt == '0);
    sr4_r  <= (r3_r < SQ_W'(DEGEN_LIM));
    ss4_r  <= (s3_r < SQ_W'(DEGEN_LIM));
  end

  // stage 5: even normalizing shifts, ratio shifts, degenerate product
  logic                   v5_r;
  logic [1:0][NRM_W-1:0]  x5_r, x5_nxt;
  norm_sb_t               sb5_r, sb5_nxt;
  logic [SH_W-1:0]        er_raw, es_raw, er, es, hsum, tgt, avail;
  logic [2*SMALL_W-1:0]   prod;

  always_comb begin
    er_raw    = SH_W'(NRM_W) - SH_W'(lr4_r);
    es_raw    = SH_W'(NRM_W) - SH_W'(ls4_r);
    er        = {er_raw[SH_W-1:1], 1'b0};
    es        = {es_raw[SH_W-1:1], 1'b0};
    x5_nxt[0] = NRM_W'(r4_r) << er;
    x5_nxt[1] = NRM_W'(s4_r) << es;
    hsum      = (er >> 1) + (es >> 1);
    tgt       = SH_W'(FRAC_Q) + hsum;
    avail     = SH_W'(NRM_W) - SH_W'(lm4_r);
    prod      = r4_r[SMALL_W-1:0] * s4_r[SMALL_W-1:0];
    sb5_nxt.neg   = neg4_r;
    sb5_nxt.zero  = zm4_r;
    sb5_nxt.degen = zr4_r | zs4_r | (sr4_r & ss4_r & (prod < DEGEN_LIM));
    sb5_nxt.m     = m4_r;
    sb5_nxt.sha   = (avail >= tgt) ? tgt : avail;
    sb5_nxt.shb   = (avail >= tgt) ? '0 : (tgt - avail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    x5_r  <= x5_nxt;
    sb5_r <= sb5_nxt;
  end

  assign out_v  = v5_r;
  assign out_x  = x5_r;
  assign out_sb = sb5_r;

endmodule
`default_nettype wire

// ===== design/sea_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sea_isqrt
// pipelined floor square root, one result bit per stage, several lanes
// ----------------------------------------------------------------------------
module sea_isqrt import sea_pkg::*; #(
  parameter int N     = ROOT_W,
  parameter int LANES = 2,
  parameter int SBW   = $bits(norm_sb_t)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  logic [LANES-1:0][2*N-1:0]   in_x,
  input  logic [SBW-1:0]              in_sb,
  output logic                        out_v,
  output logic [LANES-1:0][N-1:0]     out_root,
  output logic [SBW-1:0]              out_sb
);

  localparam int RW = N + 3;

  logic                        v_r    [N];
  logic [LANES-1:0][2*N-1:0]   x_r    [N];
  logic [LANES-1:0][RW-1:0]    rem_r  [N];
  logic [LANES-1:0][N-1:0]     root_r [N];
  logic [SBW-1:0]              sb_r   [N];

  for (genvar s = 0; s < N; s++) begin : g_st
    logic                        v_in;
    logic [LANES-1:0][2*N-1:0]   x_in, x_nxt;
    logic [LANES-1:0][RW-1:0]    rem_in, rem_nxt, remsh, trial;
    logic [LANES-1:0][N-1:0]     root_in, root_nxt;
    logic [SBW-1:0]              sb_in;
    logic [LANES-1:0]            ge;

    if (s == 0) begin : g_first
      assign v_in    = in_v;
      assign x_in    = in_x;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_rest
      assign v_in    = v_r[s-1];
      assign x_in    = x_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign sb_in   = sb_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        remsh[l]    = {rem_in[l][RW-3:0], x_in[l][2*N-1 -: 2]};
        trial[l]    = RW'({root_in[l], 2'b01});
        ge[l]       = (remsh[l] >= trial[l]);
        rem_nxt[l]  = ge[l] ? (remsh[l] - trial[l]) : remsh[l];
        root_nxt[l] = {root_in[l][N-2:0], ge[l]};
        x_nxt[l]    = {x_in[l][2*N-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else v_r[s] <= v_in;
    end

    always_ff @(posedge clk) begin
      x_r[s]    <= x_nxt;
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      sb_r[s]   <= sb_in;
    end
  end

  assign out_v    = v_r[N-1];
  assign out_root = root_r[N-1];
  assign out_sb   = sb_r[N-1];

endmodule
`default_nettype wire

// ===== design/sea_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sea_div
// pipelined restoring divider: overflow check, then one quotient bit per stage
// ----------------------------------------------------------------------------
module sea_div import sea_pkg::*; #(
  parameter int NW  = NRM_W,
  parameter int DW  = NRM_W,
  parameter int QW  = Q_W,
  parameter int SBW = $bits(tail_sb_t)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  logic [NW-1:0]   in_num,
  input  logic [DW-1:0]   in_den,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_v,
  output logic [QW-1:0]   out_q,
  output logic            out_ovf,
  output logic [SBW-1:0]  out_sb
);

  localparam int CW = DW + QW;

  // quotient would need more than QW bits
  logic            v0_r, ovf0_r;
  logic [NW-1:0]   num0_r;
  logic [DW-1:0]   den0_r;
  logic [SBW-1:0]  sb0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= in_v;
  end

  always_ff @(posedge clk) begin
    ovf0_r <= (CW'(in_num) >= {in_den, {QW{1'b0}}});
    num0_r <= in_num;
    den0_r <= in_den;
    sb0_r  <= in_sb;
  end

  logic            v_r   [QW];
  logic [NW-1:0]   rem_r [QW];
  logic [DW-1:0]   den_r [QW];
  logic [QW-1:0]   q_r   [QW];
  logic            ovf_r [QW];
  logic [SBW-1:0]  sb_r  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_st
    localparam int K = QW - 1 - j;
    logic            v_in, ovf_in, ge;
    logic [NW-1:0]   rem_in, rem_nxt;
    logic [DW-1:0]   den_in;
    logic [QW-1:0]   q_in, q_nxt;
    logic [SBW-1:0]  sb_in;
    logic [CW-1:0]   dsh;

    if (j == 0) begin : g_first
      assign v_in   = v0_r;
      assign rem_in = num0_r;
      assign den_in = den0_r;
      assign q_in   = '0;
      assign ovf_in = ovf0_r;
      assign sb_in  = sb0_r;
    end else begin : g_rest
      assign v_in   = v_r[j-1];
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign ovf_in = ovf_r[j-1];
      assign sb_in  = sb_r[j-1];
    end

    always_comb begin
      dsh      = CW'(den_in) << K;
      ge       = (CW'(rem_in) >= dsh);
      rem_nxt  = ge ? NW'(CW'(rem_in) - dsh) : rem_in;
      q_nxt    = q_in;
      q_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j] <= 1'b0;
      else v_r[j] <= v_in;
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      den_r[j] <= den_in;
      q_r[j]   <= q_nxt;
      ovf_r[j] <= ovf_in;
      sb_r[j]  <= sb_in;
    end
  end

  assign out_v   = v_r[QW-1];
  assign out_q   = q_r[QW-1];
  assign out_ovf = ovf_r[QW-1];
  assign out_sb  = sb_r[QW-1];

endmodule
`default_nettype wire

// ===== design/sea_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sea_cordic
// vectoring cordic, one rotation per stage, angle accumulated in q30
// ----------------------------------------------------------------------------
module sea_cordic import sea_pkg::*; #(
  parameter int SBW = $bits(tail_sb_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_v,
  input  logic [COS_W-1:0] in_x,
  input  logic [C_W-1:0]   in_y,
  input  logic [SBW-1:0]   in_sb,
  output logic             out_v,
  output logic [CZ_W-1:0]  out_z,
  output logic [SBW-1:0]   out_sb
);

  logic             v_r  [CORDIC_N];
  logic [CX_W-1:0]  x_r  [CORDIC_N];
  logic [CX_W-1:0]  y_r  [CORDIC_N];
  logic [CZ_W-1:0]  z_r  [CORDIC_N];
  logic [SBW-1:0]   sb_r [CORDIC_N];

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_st
    logic             v_in;
    logic [CX_W-1:0]  x_in, y_in, x_nxt, y_nxt, dx, dy;
    logic [CZ_W-1:0]  z_in, z_nxt, at;
    logic [SBW-1:0]   sb_in;

    if (i == 0) begin : g_first
      assign v_in  = in_v;
      assign x_in  = CX_W'(in_x);
      assign y_in  = CX_W'(in_y);
      assign z_in  = '0;
      assign sb_in = in_sb;
    end else begin : g_rest
      assign v_in  = v_r[i-1];
      assign x_in  = x_r[i-1];
      assign y_in  = y_r[i-1];
      assign z_in  = z_r[i-1];
      assign sb_in = sb_r[i-1];
    end

    always_comb begin
      dx = shr_tz(y_in, i);
      dy = shr_tz(x_in, i);
      at = atan_q30(i);
      // rotate toward the x axis
      if ($signed(y_in) > 0) begin
        x_nxt = x_in + dx;
        y_nxt = y_in - dy;
        z_nxt = z_in + at;
      end else begin
        x_nxt = x_in - dx;
        y_nxt = y_in + dy;
        z_nxt = z_in - at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else v_r[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      x_r[i]  <= x_nxt;
      y_r[i]  <= y_nxt;
      z_r[i]  <= z_nxt;
      sb_r[i] <= sb_in;
    end
  end

  assign out_v  = v_r[CORDIC_N-1];
  assign out_z  = z_r[CORDIC_N-1];
  assign out_sb = sb_r[CORDIC_N-1];

endmodule
`default_nettype wire

// ===== design/satellite_elevation_angle_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// satellite_elevation_angle_unit
// elevation of a satellite seen from a receiver, earth-centred positions in
// centimetres in, radians in q20 out
// ----------------------------------------------------------------------------
// a fully pipelined unit: it takes one position word on every cycle that start
// is high (busy is never raised) and gives each result as a one-cycle
// out_valid strobe, in the order the words came in; the path runs through
// the two bit-per-stage square roots (63 and 31 stages), the bit-per-stage
// divider (32 stages) and the 30 cordic stages. the receiver cannot stall
// and needs none: every cycle at most one result leaves. a degenerate
// geometry (a zero vector, or norm product below one square metre) returns
// pi/2 with out_degenerate set; a zero dot product returns zero.
// ----------------------------------------------------------------------------
module satellite_elevation_angle_unit import sea_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] in_sat_x,
  input  logic signed [IN_W-1:0] in_sat_y,
  input  logic signed [IN_W-1:0] in_sat_z,
  input  logic signed [IN_W-1:0] in_rcv_x,
  input  logic signed [IN_W-1:0] in_rcv_y,
  input  logic signed [IN_W-1:0] in_rcv_z,
  output logic                   out_valid,
  output logic signed [EL_W-1:0] out_elevation,
  output logic                   out_degenerate
);

  // the pipe never holds, so a word is taken whenever start is high
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // front end: line of sight, norms, dot product, shift counts
  logic                  pv;
  logic [1:0][NRM_W-1:0] px;
  norm_sb_t              psb;

  sea_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (accept),
    .sat    ({in_sat_z, in_sat_y, in_sat_x}),
    .rcv    ({in_rcv_z, in_rcv_y, in_rcv_x}),
    .out_v  (pv),
    .out_x  (px),
    .out_sb (psb)
  );

  // roots of both normalized squared norms, side by side
  logic                   nv;
  logic [1:0][ROOT_W-1:0] nroot;
  norm_sb_t               nsb;

  sea_isqrt #(
    .N     (ROOT_W),
    .LANES (2),
    .SBW   ($bits(norm_sb_t))
  ) u_norm_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (pv),
    .in_x     (px),
    .in_sb    (psb),
    .out_v    (nv),
    .out_root (nroot),
    .out_sb   (nsb)
  );

  // denominator: product of the roots in four partial products, then the
  // ratio shifts (numerator left, denominator right)
  logic                         m1v_r;
  logic [2*SPLIT_W-1:0]         p00_r;
  logic [ROOT_W-1:0]            p01_r, p10_r;
  logic [2*(ROOT_W-SPLIT_W)-1:0] p11_r;
  logic [NRM_W-1:0]             num1_r;
  logic [SH_W-1:0]              shb1_r;
  tail_sb_t                     t1_r, t1_nxt;

  always_comb begin
    t1_nxt.neg   = nsb.neg;
    t1_nxt.zero  = nsb.zero;
    t1_nxt.degen = nsb.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m1v_r <= 1'b0;
    else m1v_r <= nv;
  end

  always_ff @(posedge clk) begin
    p00_r  <= nroot[0][SPLIT_W-1:0] * nroot[1][SPLIT_W-1:0];
    p01_r  <= nroot[0][SPLIT_W-1:0] * nroot[1][ROOT_W-1:SPLIT_W];
    p10_r  <= nroot[0][ROOT_W-1:SPLIT_W] * nroot[1][SPLIT_W-1:0];
    p11_r  <= nroot[0][ROOT_W-1:SPLIT_W] * nroot[1][ROOT_W-1:SPLIT_W];
    num1_r <= NRM_W'(nsb.m) << nsb.sha;
    shb1_r <= nsb.shb;
    t1_r   <= t1_nxt;
  end

  logic             m2v_r;
  logic [NRM_W-1:0] den2_r, den2_nxt, num2_r;
  logic [SH_W-1:0]  shb2_r;
  tail_sb_t         t2_r;

  always_comb begin
    den2_nxt = NRM_W'(p00_r) + (NRM_W'(p01_r) << SPLIT_W) + (NRM_W'(p10_r) << SPLIT_W)
             + (NRM_W'(p11_r) << (2 * SPLIT_W));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m2v_r <= 1'b0;
    else m2v_r <= m1v_r;
  end

  always_ff @(posedge clk) begin
    den2_r <= den2_nxt;
    num2_r <= num1_r;
    shb2_r <= shb1_r;
    t2_r   <= t1_r;
  end

  logic             m3v_r;
  logic [NRM_W-1:0] den3_r, num3_r;
  tail_sb_t         t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m3v_r <= 1'b0;
    else m3v_r <= m2v_r;
  end

  always_ff @(posedge clk) begin
    den3_r <= den2_r >> shb2_r;
    num3_r <= num2_r;
    t3_r   <= t2_r;
  end

  // ratio magnitude in q30
  logic           dv, dovf;
  logic [Q_W-1:0] dq;
  tail_sb_t       dsb;

  sea_div #(
    .NW  (NRM_W),
    .DW  (NRM_W),
    .QW  (Q_W),
    .SBW ($bits(tail_sb_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (m3v_r),
    .in_num  (num3_r),
    .in_den  (den3_r),
    .in_sb   (t3_r),
    .out_v   (dv),
    .out_q   (dq),
    .out_ovf (dovf),
    .out_sb  (dsb)
  );

  // clamp to one, then the q60 term 1 - c^2
  logic           c1v_r;
  logic [C_W-1:0] c1_r, c1_nxt;
  tail_sb_t       tc1_r;

  always_comb begin
    c1_nxt = (dovf || (dq > Q_W'(Q30_ONE))) ? Q30_ONE : C_W'(dq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c1v_r <= 1'b0;
    else c1v_r <= dv;
  end

  always_ff @(posedge clk) begin
    c1_r  <= c1_nxt;
    tc1_r <= dsb;
  end

  logic            c2v_r;
  logic [C_W-1:0]  c2_r;
  logic [CC_W-1:0] csq2_r;
  tail_sb_t        tc2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c2v_r <= 1'b0;
    else c2v_r <= c1v_r;
  end

  always_ff @(posedge clk) begin
    csq2_r <= c1_r * c1_r;
    c2_r   <= c1_r;
    tc2_r  <= tc1_r;
  end

  logic                 c3v_r;
  logic [0:0][CC_W-1:0] cc3_r;
  cos_sb_t              cs3_r, cs3_nxt;

  always_comb begin
    cs3_nxt.t = tc2_r;
    cs3_nxt.c = c2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c3v_r <= 1'b0;
    else c3v_r <= c2v_r;
  end

  always_ff @(posedge clk) begin
    cc3_r[0] <= Q60_ONE - csq2_r;
    cs3_r    <= cs3_nxt;
  end

  // cosine term
  logic                  cv;
  logic [0:0][COS_W-1:0] croot;
  cos_sb_t               csb;

  sea_isqrt #(
    .N     (COS_W),
    .LANES (1),
    .SBW   ($bits(cos_sb_t))
  ) u_cos_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (c3v_r),
    .in_x     (cc3_r),
    .in_sb    (cs3_r),
    .out_v    (cv),
    .out_root (croot),
    .out_sb   (csb)
  );

  // angle of (cosine, ratio)
  logic            av;
  logic [CZ_W-1:0] az;
  tail_sb_t        asb;

  sea_cordic #(
    .SBW ($bits(tail_sb_t))
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (cv),
    .in_x   (croot[0]),
    .in_y   (csb.c),
    .in_sb  (csb.t),
    .out_v  (av),
    .out_z  (az),
    .out_sb (asb)
  );

  // clamp to [0, pi/2], round to q20, apply sign and the special cases
  logic            out_valid_r;
  logic [EL_W-1:0] elev_r, elev_nxt, mag_el;
  logic            deg_r;
  logic [CZ_W-1:0] zc, rnd;
  logic [CZ_W-RND_SH-1:0] rq;

  always_comb begin
    if (az[CZ_W-1]) zc = '0;
    else if (az > HALF_PI_Q30) zc = HALF_PI_Q30;
    else zc = az;
    rnd    = zc + RND_HALF;
    rq     = rnd[CZ_W-1:RND_SH];
    mag_el = (rq > (CZ_W-RND_SH)'(HALF_PI_Q20)) ? HALF_PI_Q20 : EL_W'(rq);
    if (asb.degen) elev_nxt = HALF_PI_Q20;
    else if (asb.zero) elev_nxt = '0;
    else if (asb.neg) elev_nxt = ~mag_el + 1'b1;
    else elev_nxt = mag_el;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= av;
  end

  always_ff @(posedge clk) begin
    elev_r <= elev_nxt;
    deg_r  <= asb.degen;
  end

  assign out_valid      = out_valid_r;
  assign out_elevation  = elev_r;
  assign out_degenerate = deg_r;

endmodule
`default_nettype wire

// ===== bench/elev_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elev_checker
// watches the position and result channels of the elevation unit, works out
// the elevation of every accepted word and compares it with what comes out
// ----------------------------------------------------------------------------
module elev_checker import sea_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic signed [IN_W-1:0] in_sat_x,
  input  logic signed [IN_W-1:0] in_sat_y,
  input  logic signed [IN_W-1:0] in_sat_z,
  input  logic signed [IN_W-1:0] in_rcv_x,
  input  logic signed [IN_W-1:0] in_rcv_y,
  input  logic signed [IN_W-1:0] in_rcv_z,
  input  logic                   out_valid,
  input  logic signed [EL_W-1:0] out_elevation,
  input  logic                   out_degenerate,
  output int                     fail_count,
  output int                     pending_count
);

  typedef struct packed {
    logic signed [EL_W-1:0] elevation;
    logic                   degenerate;
  } elev_word_t;

  localparam longint ARC_TAB [10] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149};
  localparam longint HALF_PI_FINE = 1686629713;
  localparam longint HALF_PI_OUT  = 1647099;
  localparam longint ONE_Q30      = 64'd1 << 30;

  elev_word_t elev_due [$];

  function automatic int width_of(input logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [127:0] floor_root(input logic [127:0] x);
    logic [127:0] res, probe, t;
    res = '0;
    probe = 128'd1 << 126;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      t = res + probe;
      if (x >= t) begin
        x = x - t;
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic longint trunc_shift(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // arcsine of a q30 ratio in [0, 1] by cordic vectoring on (cos, sin)
  function automatic longint arcsine_q30(input longint c);
    logic [127:0] cc;
    longint x, y, z, dx, dy, at;
    cc = (128'd1 << 60) - 128'(c) * 128'(c);
    x = longint'(floor_root(cc));
    y = c;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      at = (i < 10) ? ARC_TAB[i] : (64'd1 << (30 - i));
      dx = trunc_shift(y, i);
      dy = trunc_shift(x, i);
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + at;
      end else begin
        x = x - dx; y = y + dy; z = z - at;
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI_FINE) z = HALF_PI_FINE;
    return z;
  endfunction

  function automatic elev_word_t predict_elevation(
    input logic signed [IN_W-1:0] sx, sy, sz, rx, ry, rz);
    logic signed [127:0] rv [3];
    logic signed [127:0] dv [3];
    logic signed [127:0] dot;
    logic [127:0] r2, s2, m, den, num, q, rr, rs;
    logic [255:0] prod;
    int er, es, h, a, b;
    longint c, el;
    elev_word_t w;
    rv[0] = rx; rv[1] = ry; rv[2] = rz;
    dv[0] = 128'(signed'(sx)) - 128'(signed'(rx));
    dv[1] = 128'(signed'(sy)) - 128'(signed'(ry));
    dv[2] = 128'(signed'(sz)) - 128'(signed'(rz));
    r2 = '0; s2 = '0; dot = '0;
    for (int i = 0; i < 3; i++) begin
      r2 = r2 + rv[i] * rv[i];
      s2 = s2 + dv[i] * dv[i];
      dot = dot + rv[i] * dv[i];
    end
    prod = {128'd0, r2} * {128'd0, s2};
    if (r2 == 0 || s2 == 0 || prod < 256'd100000000) begin
      w.elevation = EL_W'(HALF_PI_OUT);
      w.degenerate = 1'b1;
      return w;
    end
    w.degenerate = 1'b0;
    m = (dot < 0) ? -dot : dot;
    if (m == 0) begin
      w.elevation = '0;
      return w;
    end
    // each squared norm normalized by an even shift before its root
    er = 126 - width_of(r2); if (er % 2) er--;
    es = 126 - width_of(s2); if (es % 2) es--;
    rr = floor_root(r2 << er);
    rs = floor_root(s2 << es);
    den = rr * rs;
    h = (er + es) / 2;
    a = 126 - width_of(m);
    if (a >= 30 + h) begin
      num = m << (30 + h); b = 0;
    end else begin
      num = m << a; b = 30 + h - a;
    end
    den = (b >= 128) ? '0 : (den >> b);
    if (den == 0) c = ONE_Q30;
    else begin
      q = num / den;
      c = (q > 128'(ONE_Q30)) ? ONE_Q30 : longint'(q);
    end
    el = (arcsine_q30(c) + 512) >>> 10;
    if (el > HALF_PI_OUT) el = HALF_PI_OUT;
    if (dot < 0) el = -el;
    w.elevation = EL_W'(el);
    return w;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    elev_word_t want;
    if (rst_n) begin
      if (start && !busy)
        elev_due.push_back(predict_elevation(in_sat_x, in_sat_y, in_sat_z,
                                             in_rcv_x, in_rcv_y, in_rcv_z));
      if (out_valid) begin
        if (elev_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: elevation %0d degenerate %0b",
                     out_elevation, out_degenerate);
          fail_count <= fail_count + 1;
        end else begin
          want = elev_due.pop_front();
          if (want.elevation !== out_elevation || want.degenerate !== out_degenerate) begin
            if (fail_count < 10)
              $display("mismatch: elevation exp %0d got %0d, degenerate exp %0b got %0b",
                       want.elevation, out_elevation, want.degenerate, out_degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= elev_due.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives position words into the elevation unit, directed corner cases first
// and then random geometry, with random gaps; the checker judges the results
// ----------------------------------------------------------------------------
module tb_top import sea_pkg::*; ();

  localparam int RANDOM_WORDS = 930;
  localparam int IDLE_LIMIT   = 4000;   // pipe is 168 deep, far above the longest gap
  localparam logic signed [IN_W-1:0] P_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] P_MIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] EARTH = 34'sd637800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] in_sat_x = '0, in_sat_y = '0, in_sat_z = '0;
  logic signed [IN_W-1:0] in_rcv_x = '0, in_rcv_y = '0, in_rcv_z = '0;
  logic out_valid;
  logic signed [EL_W-1:0] out_elevation;
  logic out_degenerate;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  satellite_elevation_angle_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sat_x(in_sat_x), .in_sat_y(in_sat_y), .in_sat_z(in_sat_z),
    .in_rcv_x(in_rcv_x), .in_rcv_y(in_rcv_y), .in_rcv_z(in_rcv_z),
    .out_valid(out_valid), .out_elevation(out_elevation),
    .out_degenerate(out_degenerate)
  );

  elev_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sat_x(in_sat_x), .in_sat_y(in_sat_y), .in_sat_z(in_sat_z),
    .in_rcv_x(in_rcv_x), .in_rcv_y(in_rcv_y), .in_rcv_z(in_rcv_z),
    .out_valid(out_valid), .out_elevation(out_elevation),
    .out_degenerate(out_degenerate),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // watchdog: any cycle with no word moving on either channel counts as idle
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("satellite_elevation_angle_unit verification failed");
      $finish;
    end
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // signed value of random magnitude up to lim
  function automatic logic signed [IN_W-1:0] spread(input int unsigned lim);
    logic signed [IN_W-1:0] v;
    v = IN_W'($urandom_range(0, lim));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic signed [IN_W-1:0] any_pattern();
    return IN_W'({$urandom, $urandom});
  endfunction

  function automatic logic signed [IN_W-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return P_MAX;
      1: return P_MIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // one position word; start stays high across back-to-back words
  task automatic send_word(input logic signed [IN_W-1:0] sx, sy, sz, rx, ry, rz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_sat_x <= sx; in_sat_y <= sy; in_sat_z <= sz;
    in_rcv_x <= rx; in_rcv_y <= ry; in_rcv_z <= rz;
    do @(posedge clk); while (busy);
  endtask

  // hold the sender off until every outstanding word has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic send_random_word();
    logic signed [IN_W-1:0] rx, ry, rz;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      // receiver near the ground, satellite out in orbit
      rx = spread(640000000); ry = spread(640000000); rz = spread(640000000);
      send_word(spread(2700000000), spread(2700000000), spread(2700000000), rx, ry, rz);
    end else if (mode == 6) begin
      send_word(any_pattern(), any_pattern(), any_pattern(),
                any_pattern(), any_pattern(), any_pattern());
    end else if (mode == 7) begin
      // short vectors around the one square metre bound
      send_word(spread(300), spread(300), spread(300), spread(300), spread(300), spread(300));
    end else if (mode == 8) begin
      // satellite close to the receiver
      rx = spread(640000000); ry = spread(640000000); rz = spread(640000000);
      send_word(rx + spread(40), ry + spread(40), rz + spread(40), rx, ry, rz);
    end else begin
      send_word(edge_value(), edge_value(), edge_value(),
                edge_value(), edge_value(), edge_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    send_word('0, '0, '0, '0, '0, '0);                         // both zero
    send_word(EARTH, '0, '0, '0, '0, '0);                      // receiver at center
    send_word(EARTH, 5, -7, EARTH, 5, -7);                     // satellite on receiver
    send_word(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, 0);
    send_word(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX);       // widest difference
    send_word(P_MAX, P_MAX, P_MAX, P_MIN, P_MIN, P_MIN);
    send_word(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN + 1);
    send_word(51, 0, 0, 50, 0, 0);                             // tiny, degenerate
    send_word(10001, 0, 0, 10000, 0, 0);                       // just at one square metre
    send_word(9999, 0, 0, 10000, 0, 0);
    send_word(EARTH * 4, 0, 0, EARTH, 0, 0);                   // zenith
    send_word(-EARTH * 3, 0, 0, EARTH, 0, 0);                  // nadir
    send_word(EARTH, 34'sd2000000000, 0, EARTH, 0, 0);         // zero dot product
    send_word(EARTH + 1, 34'sd2000000000, 0, EARTH, 0, 0);     // just above horizon
    send_word(EARTH - 1, 34'sd2000000000, 0, EARTH, 0, 0);     // just below horizon
    send_word(0, -EARTH, 34'sd2600000000, 0, -EARTH, 0);
    send_word(1, 0, 0, 0, 0, 1);
    send_word(P_MAX, 0, 0, -1, 0, 0);
    drain();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_gaps = (n >= 300 && n < 420);   // one stretch with no idling
      send_random_word();
      if (n == RANDOM_WORDS / 2) drain();
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (200) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("satellite_elevation_angle_unit verification clean");
    end else begin
      $display("satellite_elevation_angle_unit verification failed");
    end
    $finish;
  end

endmodule
